// ===== design/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the fraction arithmetic block
// Operation codes, widths and the control struct passed between units.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPW  = 16;          // operand width
    localparam int PRW  = 2 * OPW;     // product width
    localparam int NUMW = PRW + 1;     // raw numerator width (sum of products)
    localparam int MAGW = PRW + 1;     // magnitude width for the gcd cells
    localparam int CNTW = $clog2(2 * MAGW + 2);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;

    // control beat from the sequencer to a serial divider cell row
    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

// ===== design/rar_if.sv =====
// ----------------------------------------------------------------------------
// rar_in_if / rar_out_if: valid-ready channels of the fraction block
// Carry one operand beat in, one reduced result beat out.
// ----------------------------------------------------------------------------
interface rar_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [rar_pkg::OPW-1:0] num_a;
    logic signed [rar_pkg::OPW-1:0] den_a;
    logic signed [rar_pkg::OPW-1:0] num_b;
    logic signed [rar_pkg::OPW-1:0] den_b;
    logic        [1:0]              op;
    modport source (output valid, num_a, den_a, num_b, den_b, op, input ready);
    modport sink   (input valid, num_a, den_a, num_b, den_b, op, output ready);
endinterface

interface rar_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [rar_pkg::NUMW-1:0] res_num;
    logic signed [rar_pkg::PRW-1:0]  res_den;
    logic                            zero_den_error;
    modport source (output valid, res_num, res_den, zero_den_error, input ready);
    modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

// ===== design/rar_cell.sv =====
// ----------------------------------------------------------------------------
// rar_cell: one bit cell of the shift-subtract row
// Holds one bit of the remainder and of the quotient/dividend shift line,
// ripples a borrow to its upper neighbour and takes the shifted-in bit from
// its lower neighbour each cycle in which i_step is set.
// ----------------------------------------------------------------------------
module rar_cell (
    input  logic i_clk,
    input  logic i_load,      // clear remainder, load dividend bit
    input  logic i_step,      // advance one shift-subtract step
    input  logic i_dvd_bit,   // dividend bit loaded on i_load
    input  logic i_rem_in,    // remainder bit from lower neighbour (shift)
    input  logic i_q_in,      // quotient line bit from lower neighbour
    input  logic i_dvs_bit,   // divisor bit for this position
    input  logic i_bin,       // borrow in from lower neighbour
    input  logic i_take,      // subtraction fits: keep the difference
    output logic o_rem,       // stored remainder bit
    output logic o_q,         // stored quotient line bit
    output logic o_bout       // borrow out to upper neighbour
);
    logic r_rem, r_q;
    logic w_diff;

    // subtract divisor bit from the shifted remainder bit
    assign w_diff = i_rem_in ^ i_dvs_bit ^ i_bin;
    assign o_bout = (~i_rem_in & (i_dvs_bit | i_bin)) | (i_dvs_bit & i_bin);

    // hold or advance the two shift lines
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= 1'b0;
            r_q   <= i_dvd_bit;
        end else if (i_step) begin
            r_rem <= i_take ? w_diff : i_rem_in;
            r_q   <= i_q_in;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule

// ===== design/rar_divrow.sv =====
// ----------------------------------------------------------------------------
// rar_divrow: row of bit cells forming a restoring divider
// Unsigned dividend / divisor over MAGW steps; gives quotient and remainder.
// ----------------------------------------------------------------------------
module rar_divrow (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rar_pkg::t_div_ctl          i_ctl,
    input  logic [rar_pkg::MAGW-1:0]   i_dvd,
    input  logic [rar_pkg::MAGW-1:0]   i_dvs,
    output logic                       o_done,
    output logic [rar_pkg::MAGW-1:0]   o_quo,
    output logic [rar_pkg::MAGW-1:0]   o_rem
);
    localparam int W = rar_pkg::MAGW;

    logic [W-1:0]    w_rem, w_q;
    logic [W:0]      w_b;
    logic [W-1:0]    w_rem_sh, w_q_sh;
    logic            w_top, w_take, w_step;
    logic [rar_pkg::CNTW-1:0] r_cnt;
    logic            r_run;

    // shifted views: remainder takes the top quotient-line bit
    assign w_rem_sh = {w_rem[W-2:0], w_q[W-1]};
    assign w_q_sh   = {w_q[W-2:0], w_take};
    assign w_top    = w_rem[W-1];
    assign w_b[0]   = 1'b0;
    // fits when shifted remainder (W+1 bits) >= divisor
    assign w_take   = w_top | ~w_b[W];
    assign w_step   = r_run;

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_cell
            rar_cell u_cell (
                .i_clk     (i_clk),
                .i_load    (i_ctl.start),
                .i_step    (w_step),
                .i_dvd_bit (i_dvd[k]),
                .i_rem_in  (w_rem_sh[k]),
                .i_q_in    (w_q_sh[k]),
                .i_dvs_bit (i_dvs[k]),
                .i_bin     (w_b[k]),
                .i_take    (w_take),
                .o_rem     (w_rem[k]),
                .o_q       (w_q[k]),
                .o_bout    (w_b[k+1])
            );
        end
    endgenerate

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == rar_pkg::CNTW'(W - 1)) r_run <= 1'b0;
        end
    end

    assign o_done = ~r_run & ~i_ctl.start & ~i_ctl.busy;
    assign o_quo  = w_q;
    assign o_rem  = w_rem;
endmodule

// ===== design/rational_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce: signed fraction add/sub/mul/div with gcd reduction
// Top level: operand capture, cross products, Euclid sequencer, output stage.
// ----------------------------------------------------------------------------
// One beat at a time. An item forms the products (ST_MUL) and the raw sum (ST_SUM),
// then runs Euclid on the magnitudes with one 33-step pass of the bit-cell
// divider row per remainder (each pass: load, 33 steps, done; the number
// of passes is set by the Euclid iterations), then two more passes to divide
// numerator and denominator by the gcd, and posts the result in ST_OUT.
// Zero numerator or zero denominator skips reduction. Results wait in an output
// register; a new item is accepted once the result has been taken.
module rational_arith_reduce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rar_in_if.sink      i_in,
    rar_out_if.source   o_out
);
    localparam int OPW  = rar_pkg::OPW;
    localparam int PRW  = rar_pkg::PRW;
    localparam int NUMW = rar_pkg::NUMW;
    localparam int MAGW = rar_pkg::MAGW;

    rar_pkg::t_state r_state, n_state;

    logic signed [OPW-1:0]  r_na, r_da, r_nb, r_db;
    rar_pkg::t_op           r_op;
    logic signed [PRW-1:0]  r_p0, r_p1, r_d;
    logic signed [NUMW-1:0] r_n;
    logic [MAGW-1:0]        r_a, r_b, r_g;
    logic                   r_nneg, r_dneg, r_err, r_valid, r_started;
    logic signed [NUMW-1:0] r_res_num;
    logic signed [PRW-1:0]  r_res_den;

    rar_pkg::t_div_ctl w_ctl;
    logic [MAGW-1:0]   w_dvd, w_dvs, w_quo, w_rem;
    logic              w_done;
    logic              w_acc;
    logic signed [NUMW-1:0] w_p0x, w_p1x;
    logic [MAGW-1:0]   w_qneg;

    assign w_acc       = i_in.valid & i_in.ready;
    assign i_in.ready  = (r_state == rar_pkg::ST_IDLE) & ~r_valid;
    assign o_out.valid = r_valid;
    assign o_out.res_num = r_res_num;
    assign o_out.res_den = r_res_den;
    assign o_out.zero_den_error = r_err;

    assign w_p0x  = NUMW'(r_p0);
    assign w_p1x  = NUMW'(r_p1);
    assign w_qneg = MAGW'(0) - w_quo;

    // divider row operands follow the phase; the numerator pass loads the
    // raw numerator magnitude directly
    always_comb begin
        w_dvd = r_a;
        w_dvs = r_b;
        case (r_state)
            rar_pkg::ST_DIVN: begin
                w_dvd = r_nneg ? MAGW'(-r_n) : MAGW'(r_n);
                w_dvs = r_g;
            end
            rar_pkg::ST_DIVD: begin w_dvd = r_b; w_dvs = r_g; end
            default:          begin w_dvd = r_a; w_dvs = r_b; end
        endcase
    end

    rar_divrow u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rar_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // next state and divider start
    always_comb begin
        n_state     = r_state;
        w_ctl.start = 1'b0;
        w_ctl.busy  = 1'b0;
        case (r_state)
            rar_pkg::ST_IDLE: if (w_acc) n_state = rar_pkg::ST_MUL;
            rar_pkg::ST_MUL:  n_state = rar_pkg::ST_SUM;
            rar_pkg::ST_SUM:  n_state = rar_pkg::ST_GCD;
            rar_pkg::ST_GCD: begin
                if (r_err || r_a == '0) begin
                    n_state = rar_pkg::ST_OUT;
                end else if (!r_started) begin
                    w_ctl.start = (r_b != '0);
                    if (r_b == '0) n_state = rar_pkg::ST_DIVN;
                end else if (w_done) begin
                    if (w_rem == '0) n_state = rar_pkg::ST_DIVN;
                end
            end
            rar_pkg::ST_DIVN: begin
                if (!r_started) w_ctl.start = 1'b1;
                else if (w_done) n_state = rar_pkg::ST_DIVD;
            end
            rar_pkg::ST_DIVD: begin
                if (!r_started) w_ctl.start = 1'b1;
                else if (w_done) n_state = rar_pkg::ST_OUT;
            end
            rar_pkg::ST_OUT: n_state = rar_pkg::ST_IDLE;
            default: n_state = rar_pkg::ST_IDLE;
        endcase
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
        end else begin
            if (w_ctl.start)                 r_started <= 1'b1;
            else if (w_done && r_started)    r_started <= 1'b0;
            if (r_state == rar_pkg::ST_OUT)  r_valid <= 1'b1;
            else if (o_out.ready)            r_valid <= 1'b0;
        end
    end

    // datapath: capture, products, Euclid, division, result
    always_ff @(posedge i_clk) begin
        case (r_state)
            rar_pkg::ST_IDLE: if (w_acc) begin
                r_na <= i_in.num_a;
                r_da <= i_in.den_a;
                r_nb <= i_in.num_b;
                r_db <= i_in.den_b;
                r_op <= rar_pkg::t_op'(i_in.op);
            end
            rar_pkg::ST_MUL: begin
                // hold the two numerator products and the denominator
                case (r_op)
                    rar_pkg::OP_MUL: begin
                        r_p0 <= r_na * r_nb; r_p1 <= '0; r_d <= r_da * r_db;
                    end
                    rar_pkg::OP_DIV: begin
                        r_p0 <= r_na * r_db; r_p1 <= '0; r_d <= r_da * r_nb;
                    end
                    default: begin
                        r_p0 <= r_na * r_db; r_p1 <= r_da * r_nb; r_d <= r_da * r_db;
                    end
                endcase
            end
            rar_pkg::ST_SUM: begin
                logic signed [NUMW-1:0] v_n;
                v_n = (r_op == rar_pkg::OP_SUB) ? (w_p0x - w_p1x) : (w_p0x + w_p1x);
                r_n    <= v_n;
                r_nneg <= v_n[NUMW-1];
                r_dneg <= r_d[PRW-1];
                r_err  <= (r_d == '0);
                r_a    <= v_n[NUMW-1] ? MAGW'(-v_n) : MAGW'(v_n);
                r_b    <= r_d[PRW-1] ? (MAGW'(0) - MAGW'(r_d)) : MAGW'(r_d);
                r_res_num <= v_n;
                r_res_den <= r_d;
            end
            rar_pkg::ST_GCD: begin
                if (!(r_err || r_a == '0)) begin
                    if (!r_started && r_b == '0) begin
                        r_g <= r_a;
                    end else if (r_started && w_done) begin
                        // advance Euclid: (a, b) <- (b, a mod b)
                        if (w_rem == '0) r_g <= r_b;
                        else begin r_a <= r_b; r_b <= w_rem; end
                    end
                end
            end
            rar_pkg::ST_DIVN: begin
                if (!r_started) begin
                    r_a <= r_nneg ? MAGW'(-r_n) : MAGW'(r_n);
                    r_b <= r_dneg ? (MAGW'(0) - MAGW'(r_d)) : MAGW'(r_d);
                end else if (w_done) begin
                    r_res_num <= NUMW'(r_nneg ? w_qneg : w_quo);
                end
            end
            rar_pkg::ST_DIVD: begin
                if (r_started && w_done)
                    r_res_den <= PRW'(r_dneg ? w_qneg : w_quo);
            end
            default: ;
        endcase
    end

    // a result beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.res_num))
        else $error("result changed under stall");
    // no input taken while a result waits
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input accepted with result pending");
    // error flag pairs with a zero denominator
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_den_error |-> o_out.res_den == '0)
        else $error("error flag without zero denominator");
endmodule

// ===== sim/rational_arith_reduce_test.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_test: self-checking bench for the fraction block
// Drives operand beats in random bursts, stalls the result side, predicts
// every reduced fraction and compares each result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rational_arith_reduce_test;

    typedef struct packed {
        logic signed [rar_pkg::NUMW-1:0] num;
        logic signed [rar_pkg::PRW-1:0]  den;
        logic                            err;
    } t_frac;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   long_hold = 1'b0;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Hold expected fractions and compare result beats in order
    class fraction_board;
        t_frac pending[$];

        function longint gcd64(longint a, longint b);
            longint t;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function void note_operands(logic signed [rar_pkg::OPW-1:0] na,
                                    logic signed [rar_pkg::OPW-1:0] da,
                                    logic signed [rar_pkg::OPW-1:0] nb,
                                    logic signed [rar_pkg::OPW-1:0] db,
                                    rar_pkg::t_op op);
            longint n, d, g, an, ad;
            t_frac  f;
            case (op)
                rar_pkg::OP_ADD: begin
                    n = longint'(na) * db + longint'(da) * nb;
                    d = longint'(da) * db;
                end
                rar_pkg::OP_SUB: begin
                    n = longint'(na) * db - longint'(da) * nb;
                    d = longint'(da) * db;
                end
                rar_pkg::OP_MUL: begin
                    n = longint'(na) * nb;
                    d = longint'(da) * db;
                end
                default: begin
                    n = longint'(na) * db;
                    d = longint'(da) * nb;
                end
            endcase
            f.err = (d == 0);
            if (d != 0 && n != 0) begin
                an = (n < 0) ? -n : n;
                ad = (d < 0) ? -d : d;
                g  = gcd64(an, ad);
                n  = n / g;
                d  = d / g;
            end
            f.num = n[rar_pkg::NUMW-1:0];
            f.den = d[rar_pkg::PRW-1:0];
            pending.push_back(f);
        endfunction

        task check_result(t_frac got);
            t_frac want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d", got.num, got.den));
                return;
            end
            want = pending.pop_front();
            if (got.num !== want.num)
                report_mismatch($sformatf("res_num %0d, want %0d", got.num, want.num));
            if (got.den !== want.den)
                report_mismatch($sformatf("res_den %0d, want %0d", got.den, want.den));
            if (got.err !== want.err)
                report_mismatch($sformatf("zero_den_error %0b, want %0b", got.err, want.err));
        endtask
    endclass

    fraction_board board = new();

    rar_in_if  in_ch ();
    rar_out_if out_ch ();

    rational_arith_reduce uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.num_a = '0;
        in_ch.den_a = '0;
        in_ch.num_b = '0;
        in_ch.den_b = '0;
        in_ch.op    = rar_pkg::OP_ADD;
        out_ch.ready = 1'b0;
    end

    // Offer one operand beat and hold it until taken
    task automatic send_operands(logic [rar_pkg::OPW-1:0] na, logic [rar_pkg::OPW-1:0] da,
                                 logic [rar_pkg::OPW-1:0] nb, logic [rar_pkg::OPW-1:0] db,
                                 rar_pkg::t_op op);
        in_ch.valid <= 1'b1;
        in_ch.num_a <= na;
        in_ch.den_a <= da;
        in_ch.num_b <= nb;
        in_ch.den_b <= db;
        in_ch.op    <= op;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid for a gap; a zero gap leaves the line as it is
    task automatic go_idle(int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [rar_pkg::OPW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 8)) - 16'd4;
            4, 5: return 16'($urandom_range(0, 60)) - 16'd30;
            default: return 16'($urandom);
        endcase
    endfunction

    // Note every accepted operand beat
    always @(posedge i_clk)
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_operands(in_ch.num_a, in_ch.den_a, in_ch.num_b, in_ch.den_b,
                                rar_pkg::t_op'(in_ch.op));

    // Check every accepted result beat
    always @(posedge i_clk)
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result('{out_ch.res_num, out_ch.res_den, out_ch.zero_den_error});

    // Stall the result side on a pattern of its own, with one long hold
    initial begin
        int phase;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            phase++;
            if (long_hold)
                out_ch.ready <= 1'b0;
            else if ((phase / 200) % 3 == 0)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog: count cycles in which no beat moves
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || long_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        rar_pkg::t_op ops[4];
        int  sent, burst;
        ops = '{rar_pkg::OP_ADD, rar_pkg::OP_SUB, rar_pkg::OP_MUL, rar_pkg::OP_DIV};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, each operation, zero numerator and zero denominator
        foreach (ops[k]) begin
            send_operands(16'h8000, 16'h8000, 16'h8000, 16'h8000, ops[k]);
            send_operands(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, ops[k]);
            send_operands(16'h0000, 16'd3, 16'h0000, 16'd5, ops[k]);
            send_operands(16'd1, 16'h0000, 16'd2, 16'h0000, ops[k]);
            send_operands(16'h0000, 16'h0000, 16'h0000, 16'h0000, ops[k]);
        end
        send_operands(16'd6, 16'hFFF7, 16'd4, 16'd6, rar_pkg::OP_ADD);
        send_operands(16'd1, 16'd2, 16'd1, 16'd2, rar_pkg::OP_SUB);

        // Pause until every expected result has come
        go_idle(1);
        while (board.pending.size() != 0) @(posedge i_clk);

        // Hold the result side off while operands keep coming
        long_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            repeat (3) send_operands(pick_operand(), pick_operand(), pick_operand(),
                                     pick_operand(), rar_pkg::t_op'($urandom_range(0, 3)));
        join
        go_idle(1);

        // Random bursts with random gaps
        sent = 0;
        while (sent < 1700) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_operands(pick_operand(), pick_operand(), pick_operand(),
                              pick_operand(), rar_pkg::t_op'($urandom_range(0, 3)));
                sent++;
            end
            go_idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 100));
        end
        go_idle(1);

        // Drain, then let the latency pass
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
